@@ src/fmns_pkg.sv @@
// Shared types, constants and lookup functions for the FM note register sequencer.
package fmns_pkg;

   // Voice channels and stored patches
   localparam int CHANNELS    = 9;
   localparam int PATCH_COUNT = 5;
   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Note event codes
   localparam logic OP_NOTE_ON  = 1'b0;
   localparam logic OP_NOTE_OFF = 1'b1;

   // Synth register bases
   localparam logic [7:0] REG_MULT    = 8'h20;
   localparam logic [7:0] REG_LEVEL   = 8'h40;
   localparam logic [7:0] REG_AD      = 8'h60;
   localparam logic [7:0] REG_SR      = 8'h80;
   localparam logic [7:0] REG_FNUM_LO = 8'hA0;
   localparam logic [7:0] REG_KEY     = 8'hB0;
   localparam logic [7:0] REG_FB      = 8'hC0;
   localparam logic [7:0] REG_WAVE    = 8'hE0;
   localparam logic [7:0] KEY_ON_BIT  = 8'h20;

   // Volume saturation and fnum arithmetic
   localparam int VOL_MAX   = 63;
   localparam int FNUM_MAX  = 1023;
   localparam int BLOCK_MAX = 7;
   // hz * 2^20 / 49716 == hz * 2^18 / (49716 / 4)
   localparam longint unsigned FNUM_DIV = 49716 / 4;
   // exact for 16-bit hz: (hz * ceil(2^48 / 12429)) >> 30
   localparam int HZ_W        = 16;
   localparam int RECIP_W     = 35;
   localparam int RECIP_LO_W  = 18;
   localparam int RECIP_SHIFT = 30;
   localparam int PROD_W      = HZ_W + RECIP_W;
   localparam int QUO_BITS    = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] FNUM_RECIP =
      RECIP_W'(((64'd1 << (18 + RECIP_SHIFT)) / FNUM_DIV) + 64'd1);

   // Position of each write within a note-on run
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_KEY_OFF  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MOD_MULT = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MOD_LVL  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MOD_AD   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_MOD_SR   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MOD_WAVE = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CAR_MULT = 4'd6;
   localparam logic [STEP_W-1:0] STEP_CAR_LVL  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_CAR_AD   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_CAR_SR   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_CAR_WAVE = 4'd10;
   localparam logic [STEP_W-1:0] STEP_FB       = 4'd11;
   localparam logic [STEP_W-1:0] STEP_FNUM_LO  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_KEY_ON   = 4'd13;

   typedef struct packed {
      logic [7:0] mod_mult;
      logic [7:0] mod_level;
      logic [7:0] mod_ad;
      logic [7:0] mod_sr;
      logic [7:0] mod_wave;
      logic [7:0] car_mult;
      logic [7:0] car_level;
      logic [7:0] car_ad;
      logic [7:0] car_sr;
      logic [7:0] car_wave;
      logic [7:0] fb_conn;
   } voice_type;

   // Divider result handed to the sequencer
   typedef struct packed {
      logic       done;
      logic [9:0] fnum;
      logic [2:0] block;
   } fnum_result_type;

   // Patch ROM; unknown instruments fall back to patch 0
   function automatic voice_type patch_rom(input logic [2:0] ins);
      logic [2:0] sel;
      voice_type  v;
      sel = (32'(ins) < PATCH_COUNT) ? ins : 3'd0;
      case (sel)
         3'd1: v = '{8'h02, 8'h00, 8'hA5, 8'h33, 8'h00,
                     8'h02, 8'h00, 8'hA5, 8'h33, 8'h00, 8'h06};
         3'd2: v = '{8'h05, 8'h00, 8'hF0, 8'h97, 8'h01,
                     8'h02, 8'h00, 8'hF0, 8'hA7, 8'h00, 8'h0A};
         3'd3: v = '{8'h00, 8'h00, 8'hF8, 8'h65, 8'h00,
                     8'h00, 8'h00, 8'hF6, 8'h65, 8'h00, 8'h08};
         3'd4: v = '{8'h21, 8'h00, 8'hFF, 8'h08, 8'h00,
                     8'h21, 8'h00, 8'hFF, 8'h08, 8'h00, 8'h0E};
         default: v = '{8'h01, 8'h00, 8'hF3, 8'h75, 8'h00,
                        8'h01, 8'h00, 8'hF3, 8'h75, 8'h00, 8'h0E};
      endcase
      return v;
   endfunction

   // Operator slot offsets per channel
   function automatic logic [4:0] mod_slot(input logic [3:0] ch);
      logic [4:0] s;
      case (ch)
         4'd1: s = 5'd1;
         4'd2: s = 5'd2;
         4'd3: s = 5'd6;
         4'd4: s = 5'd7;
         4'd5: s = 5'd8;
         4'd6: s = 5'd12;
         4'd7: s = 5'd13;
         4'd8: s = 5'd14;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   function automatic logic [4:0] car_slot(input logic [3:0] ch);
      logic [4:0] s;
      case (ch)
         4'd1: s = 5'd4;
         4'd2: s = 5'd5;
         4'd3: s = 5'd9;
         4'd4: s = 5'd10;
         4'd5: s = 5'd11;
         4'd6: s = 5'd15;
         4'd7: s = 5'd16;
         4'd8: s = 5'd17;
         default: s = 5'd3;
      endcase
      return s;
   endfunction

endpackage

@@ src/fmns_if.sv @@
// Handshake channels of the FM note register sequencer.
interface fmns_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [3:0]  channel;
   logic [15:0] freq_hz;
   logic [6:0]  volume;
   logic [2:0]  instrument;

   modport source (output valid, op, channel, freq_hz, volume, instrument, input ready);
   modport sink   (input valid, op, channel, freq_hz, volume, instrument, output ready);
endinterface

interface fmns_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reg_addr;
   logic [7:0] reg_value;
   logic       last;

   modport source (output valid, reg_addr, reg_value, last, input ready);
   modport sink   (input valid, reg_addr, reg_value, last, output ready);
endinterface

interface fmns_csr_if;
   logic valid;
   logic ready;
   logic ready_cfg;

   modport source (output valid, ready_cfg, input ready);
   modport sink   (input valid, ready_cfg, output ready);
endinterface

@@ src/fmns_ram.sv @@
// Generic single-port-write, registered-read RAM.
module fmns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/fmns_fnum.sv @@
// Reciprocal-multiply fnum unit with block normalization and clamp.
module fmns_fnum import fmns_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [15:0]     freq_hz,
   output fnum_result_type result
);

   typedef enum logic [1:0] {D_IDLE, D_MUL, D_SUM, D_NORM} div_state_type;

   div_state_type                  state_ff, state_in;
   logic [HZ_W-1:0]                hz_ff, hz_in;
   logic [HZ_W+RECIP_LO_W-1:0]     plo_ff, plo_in;
   logic [PROD_W-RECIP_LO_W-1:0]   phi_ff, phi_in;
   logic [QUO_BITS-1:0]            quo_ff, quo_in;
   logic [2:0]                     blk_ff, blk_in;
   logic [9:0]                     fnum_ff, fnum_in;
   logic                           done_ff, done_in;
   logic [PROD_W-1:0]              prod;

   // Two partial products, then their sum, then block normalization
   always_comb begin
      state_in = state_ff;
      hz_in    = hz_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      quo_in   = quo_ff;
      blk_in   = blk_ff;
      fnum_in  = fnum_ff;
      done_in  = done_ff;
      prod     = {phi_ff, {RECIP_LO_W{1'b0}}} + PROD_W'(plo_ff);
      if (start) begin
         state_in = D_MUL;
         hz_in    = freq_hz;
         blk_in   = '0;
         done_in  = 1'b0;
      end else begin
         case (state_ff)
            D_MUL: begin
               // 16 x 18 low and 16 x 17 high partial products
               plo_in   = (HZ_W+RECIP_LO_W)'(hz_ff) *
                          (HZ_W+RECIP_LO_W)'(FNUM_RECIP[RECIP_LO_W-1:0]);
               phi_in   = (PROD_W-RECIP_LO_W)'(hz_ff) *
                          (PROD_W-RECIP_LO_W)'(FNUM_RECIP[RECIP_W-1:RECIP_LO_W]);
               state_in = D_SUM;
            end
            D_SUM: begin
               quo_in   = prod[PROD_W-1:RECIP_SHIFT];
               state_in = D_NORM;
            end
            D_NORM: begin
               // raise block while fnum overflows 10 bits
               if (quo_ff > QUO_BITS'(FNUM_MAX) && blk_ff != 3'(BLOCK_MAX)) begin
                  quo_in = quo_ff >> 1;
                  blk_in = blk_ff + 3'd1;
               end else begin
                  fnum_in  = (quo_ff > QUO_BITS'(FNUM_MAX)) ? 10'(FNUM_MAX) : quo_ff[9:0];
                  done_in  = 1'b1;
                  state_in = D_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      hz_ff   <= hz_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      quo_ff  <= quo_in;
      blk_ff  <= blk_in;
      fnum_ff <= fnum_in;
   end

   assign result = '{done: done_ff, fnum: fnum_ff, block: blk_ff};

endmodule

@@ src/fm_note_register_sequencer.sv @@
// Top level: turns note events into runs of FM synth register writes.
// An accepted item sets the emit state, whose first load fills the output register;
// then one write per cycle while the output is ready. Note-on: 14 writes; the fnum
// writes wait for the divider. Note-off: 1 write. A dropped item starts no run.
// Synchronous reset clears the ready register, the output valid and all channel
//   key words (valid bits make unwritten words read as zero).
module fm_note_register_sequencer import fmns_pkg::*; (
   input logic        clock,
   input logic        reset,
   fmns_req_if.sink   req_bus,
   fmns_rsp_if.source rsp_bus,
   fmns_csr_if.sink   csr_bus
);

   typedef enum logic {ST_IDLE, ST_EMIT} seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              op_ff, op_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [6:0]        vol_ff, vol_in;
   logic [2:0]        ins_ff, ins_in;
   logic              ready_cfg_ff;
   logic [CHANNELS-1:0] kw_valid_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_addr_ff, rsp_addr_in;
   logic [7:0]        rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_acc;
   logic              keep;
   logic              slot_free;
   logic              load;
   logic              ram_wr;
   logic [7:0]        ram_rd_data;
   logic [7:0]        stored_kw;
   logic [7:0]        key_word;
   logic [7:0]        atten;
   logic [5:0]        vol_sat;
   logic [7:0]        m_off, c_off, ch_off;
   voice_type         voice;
   fnum_result_type   fn_res;

   // Input and configuration handshakes
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign keep          = ready_cfg_ff && ({1'b0, req_bus.channel} < 5'(CHANNELS));

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_cfg_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         ready_cfg_ff <= csr_bus.ready_cfg;
      end
   end

   // Channel key word store: read on accept, written on key-on
   fmns_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_kw_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ch_ff),
      .wr_data (key_word),
      .rd_en   (req_acc),
      .rd_addr (req_bus.channel[CH_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_valid_ff <= '0;
      end else if (ram_wr) begin
         kw_valid_ff[ch_ff] <= 1'b1;
      end
   end

   // fnum unit runs while the patch writes go out
   fmns_fnum u_fnum (
      .clock   (clock),
      .reset   (reset),
      .start   (req_acc && keep && req_bus.op == OP_NOTE_ON),
      .freq_hz (req_bus.freq_hz),
      .result  (fn_res)
   );

   // Write contents for the current step
   assign stored_kw = kw_valid_ff[ch_ff] ? ram_rd_data : 8'h00;
   assign voice     = patch_rom(ins_ff);
   assign vol_sat   = (vol_ff > 7'(VOL_MAX)) ? 6'(VOL_MAX) : vol_ff[5:0];
   assign atten     = 8'(VOL_MAX) - {2'b00, vol_sat};
   assign key_word  = KEY_ON_BIT | {3'b000, fn_res.block, fn_res.fnum[9:8]};
   assign m_off     = {3'b000, mod_slot(4'(ch_ff))};
   assign c_off     = {3'b000, car_slot(4'(ch_ff))};
   assign ch_off    = 8'(ch_ff);

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign load      = (state_ff == ST_EMIT) && slot_free &&
                      (step_ff < STEP_FNUM_LO || fn_res.done);
   assign ram_wr    = load && step_ff == STEP_KEY_ON;

   always_comb begin
      rsp_addr_in  = rsp_addr_ff;
      rsp_value_in = rsp_value_ff;
      case (step_ff)
         STEP_KEY_OFF:  begin rsp_addr_in = REG_KEY + ch_off;     rsp_value_in = stored_kw & ~KEY_ON_BIT; end
         STEP_MOD_MULT: begin rsp_addr_in = REG_MULT + m_off;     rsp_value_in = voice.mod_mult;  end
         STEP_MOD_LVL:  begin rsp_addr_in = REG_LEVEL + m_off;    rsp_value_in = voice.mod_level; end
         STEP_MOD_AD:   begin rsp_addr_in = REG_AD + m_off;       rsp_value_in = voice.mod_ad;    end
         STEP_MOD_SR:   begin rsp_addr_in = REG_SR + m_off;       rsp_value_in = voice.mod_sr;    end
         STEP_MOD_WAVE: begin rsp_addr_in = REG_WAVE + m_off;     rsp_value_in = voice.mod_wave;  end
         STEP_CAR_MULT: begin rsp_addr_in = REG_MULT + c_off;     rsp_value_in = voice.car_mult;  end
         STEP_CAR_LVL:  begin rsp_addr_in = REG_LEVEL + c_off;
                              rsp_value_in = voice.car_level | atten; end
         STEP_CAR_AD:   begin rsp_addr_in = REG_AD + c_off;       rsp_value_in = voice.car_ad;    end
         STEP_CAR_SR:   begin rsp_addr_in = REG_SR + c_off;       rsp_value_in = voice.car_sr;    end
         STEP_CAR_WAVE: begin rsp_addr_in = REG_WAVE + c_off;     rsp_value_in = voice.car_wave;  end
         STEP_FB:       begin rsp_addr_in = REG_FB + ch_off;      rsp_value_in = voice.fb_conn;   end
         STEP_FNUM_LO:  begin rsp_addr_in = REG_FNUM_LO + ch_off; rsp_value_in = fn_res.fnum[7:0]; end
         STEP_KEY_ON:   begin rsp_addr_in = REG_KEY + ch_off;     rsp_value_in = key_word;        end
         default: begin
         end
      endcase
      if (!load) begin
         rsp_addr_in  = rsp_addr_ff;
         rsp_value_in = rsp_value_ff;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      vol_in       = vol_ff;
      ins_in       = ins_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && keep) begin
               state_in = ST_EMIT;
               step_in  = STEP_KEY_OFF;
               op_in    = req_bus.op;
               ch_in    = req_bus.channel[CH_W-1:0];
               vol_in   = req_bus.volume;
               ins_in   = req_bus.instrument;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (step_ff == STEP_KEY_OFF && op_ff == OP_NOTE_OFF) ||
                              step_ff == STEP_KEY_ON;
               step_in      = step_ff + STEP_W'(1);
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff      <= step_in;
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      vol_ff       <= vol_in;
      ins_ff       <= ins_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.reg_addr  = rsp_addr_ff;
   assign rsp_bus.reg_value = rsp_value_ff;
   assign rsp_bus.last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // key word store is written only by the key-on write of a note-on
   a_kw_write: assert property (@(posedge clock) disable iff (reset)
      ram_wr |-> (state_ff == ST_EMIT && op_ff == OP_NOTE_ON))
      else $error("key word written outside key-on");

   // fnum writes wait for the divider
   a_fnum_ready: assert property (@(posedge clock) disable iff (reset)
      (load && step_ff >= STEP_FNUM_LO) |-> fn_res.done)
      else $error("fnum write before divider finished");

   // the last write of a run frees the input side
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after last write");

   // dropped items start no run
   a_drop: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !keep) |=> (state_ff == ST_IDLE && !$rose(rsp_valid_ff)))
      else $error("dropped item produced a write");
`endif

endmodule
